// File: sv/sdhs_pkg.sv
package sdhs_pkg;

	// Field widths and default store depth
	localparam int CYL_BITS  = 16;
	localparam int DC_BITS   = 17;
	localparam int MOVE_BITS = 18;
	localparam int MAX_REQUESTS_DEF = 64;

	// Register reset values
	localparam logic [DC_BITS-1:0] DC_RESET  = 17'd200;
	localparam logic               SUF_RESET = 1'b1;

	// Register index, taken from paddr[2]
	localparam logic REG_DISK_CYLINDERS = 1'b0;
	localparam logic REG_SWEEP_UP_FIRST = 1'b1;

	// Input word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef struct packed {
		logic [DC_BITS-1:0] disk_cylinders;
		logic               sweep_up_first;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic ld_start;     // capture request, point at top of store
		logic ld_shift;     // move entry one place up, step down
		logic ld_place;     // write request into its slot, bump count
		logic run_start;    // capture head, clear run state
		logic rd_en;        // issue store read
		logic rd_dn;        // read below the index rather than at it
		logic scan_next;    // step the split search
		logic set_split;    // hold split point
		logic em_calc;      // serve the request just read
		logic end_trav;     // travel to the disk end, start return sweep
		logic clear_count;  // empty the store
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic count_zero;
		logic idx_zero;
		logic idx_at_count;
		logic rd_gt_ld;
		logic rd_gt_head;
		logic dir_dn;
		logic sweep_done;
		logic sweep2;
		logic all_done;
		logic em_last;
	} status_t;

endpackage

// File: sv/scan_disk_head_scheduler.sv
// SCAN (elevator) disk head scheduler.
// Input channel (in_valid/in_ready) takes one word at a time: kind load adds
// cylinder to the request store, kind run starts a schedule from head
// position cylinder. The store is kept in ascending order by insertion on
// each load, shifting larger requests up one place at a time; a load
// into a full store is taken and dropped.
// A run searches the split point, reading each request at or below the head,
// then serves each request in turn, waiting while the receiver holds the
// word, with one travel to the disk end before the return sweep.
// All these steps share the single store port.
// Output channel (out_valid/out_ready) gives one word per served request,
// is_last on the final one; an empty run gives one word with is_empty set.
// No new input word is taken until the last result of a run has gone, and
// a stalled receiver simply holds the block in its output state.
// Reset empties the store and sets 200 cylinders, sweeping up first.
// Users write registers over the APB port only while idle; not enforced.
module scan_disk_head_scheduler import sdhs_pkg::*; #(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// register port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input words
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [CYL_BITS-1:0]  cylinder,
	// result words
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CYL_BITS-1:0]  served_cylinder,
	output logic [MOVE_BITS-1:0] running_movement,
	output logic                 is_last,
	output logic                 is_empty
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	assign pready = 1'b1;

	sdhs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Sequencer: decides every step of load insertion, split search and sweeps
	sdhs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Store, indices and movement arithmetic; holds the result word too
	sdhs_datapath #(
		.MAX_REQUESTS (MAX_REQUESTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg              (cfg),
		.cylinder         (cylinder),
		.st               (st),
		.served_cylinder  (served_cylinder),
		.running_movement (running_movement),
		.is_empty         (is_empty)
	);

	// The final word of a run is the one where every request has been served
	assign is_last = st.all_done;

	// Never take a word while a result is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result is pending");

	// An empty run reports one final word with zero movement
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (is_last && running_movement == '0))
		else $error("empty run word malformed");

	// Never start an insertion into a full store
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_start |-> !st.full)
		else $error("load started into full store");

	// Return to idle once the last word of a run has gone
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && is_last) |=> (in_ready && st.count_zero))
		else $error("block did not return to idle after last word");

endmodule

// File: sv/sdhs_cfg.sv
module sdhs_cfg import sdhs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	logic [DC_BITS-1:0] disk_cylinders_q;
	logic               sweep_up_first_q;
	logic               wr_en;

	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_cylinders_q <= DC_RESET;
			sweep_up_first_q <= SUF_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_DISK_CYLINDERS: disk_cylinders_q <= pwdata[DC_BITS-1:0];
				REG_SWEEP_UP_FIRST: sweep_up_first_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DISK_CYLINDERS: prdata = {{(32-DC_BITS){1'b0}}, disk_cylinders_q};
			REG_SWEEP_UP_FIRST: prdata = {31'd0, sweep_up_first_q};
			default:            prdata = 32'd0;
		endcase
	end

	assign cfg.disk_cylinders = disk_cylinders_q;
	assign cfg.sweep_up_first = sweep_up_first_q;

endmodule

// File: sv/sdhs_datapath.sv
module sdhs_datapath import sdhs_pkg::*; #(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  cfg_t                 cfg,
	input  logic [CYL_BITS-1:0]  cylinder,
	output status_t              st,
	output logic [CYL_BITS-1:0]  served_cylinder,
	output logic [MOVE_BITS-1:0] running_movement,
	output logic                 is_empty
);

	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CW = $clog2(MAX_REQUESTS + 1);

	logic [CYL_BITS-1:0]  mem [MAX_REQUESTS];
	logic [CYL_BITS-1:0]  rd_data_q;
	logic [CYL_BITS-1:0]  ld_q;
	logic [CYL_BITS-1:0]  out_cyl_q;
	logic [DC_BITS-1:0]   head_q;
	logic [MOVE_BITS-1:0] total_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        split_q;
	logic [CW-1:0]        em_q;
	logic                 sweep2_q;
	logic                 empty_q;

	logic [CW-1:0]        idx_dn;
	logic [AW-1:0]        rd_addr;
	logic                 dir_up;
	logic [DC_BITS-1:0]   rd_ext;
	logic [DC_BITS-1:0]   end_cyl;
	logic [DC_BITS-1:0]   move_to;
	logic [DC_BITS-1:0]   travel;
	logic [MOVE_BITS:0]   sum;
	logic [MOVE_BITS-1:0] total_sat;

	assign idx_dn  = idx_q - 1'b1;
	assign rd_addr = cmd.rd_dn ? idx_dn[AW-1:0] : idx_q[AW-1:0];
	assign dir_up  = cfg.sweep_up_first ^ sweep2_q;
	assign rd_ext  = {{(DC_BITS-CYL_BITS){1'b0}}, rd_data_q};
	assign end_cyl = (cfg.disk_cylinders == '0) ? '0 : cfg.disk_cylinders - 1'b1;

	// Target of this move: the request read, or the disk end
	assign move_to = cmd.end_trav ? (cfg.sweep_up_first ? end_cyl : '0) : rd_ext;
	assign travel  = (move_to > head_q) ? move_to - head_q : head_q - move_to;
	assign sum     = {1'b0, total_q} + {{(MOVE_BITS+1-DC_BITS){1'b0}}, travel};
	assign total_sat = sum[MOVE_BITS] ? '1 : sum[MOVE_BITS-1:0];

	// Store: one write, one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.ld_shift)
			mem[idx_q[AW-1:0]] <= rd_data_q;
		else if (cmd.ld_place)
			mem[idx_q[AW-1:0]] <= ld_q;
		if (cmd.rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_count) begin
			count_q <= '0;
		end else if (cmd.ld_place) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_start) begin
			ld_q  <= cylinder;
			idx_q <= count_q;
		end
		if (cmd.ld_shift)
			idx_q <= idx_dn;
		if (cmd.run_start) begin
			head_q    <= {{(DC_BITS-CYL_BITS){1'b0}}, cylinder};
			total_q   <= '0;
			out_cyl_q <= '0;
			idx_q     <= '0;
			em_q      <= '0;
			sweep2_q  <= 1'b0;
			empty_q   <= (count_q == '0);
		end
		if (cmd.scan_next)
			idx_q <= idx_q + 1'b1;
		if (cmd.set_split)
			split_q <= idx_q;
		if (cmd.em_calc) begin
			head_q    <= rd_ext;
			total_q   <= total_sat;
			out_cyl_q <= rd_data_q;
			idx_q     <= dir_up ? idx_q + 1'b1 : idx_dn;
			em_q      <= em_q + 1'b1;
		end
		if (cmd.end_trav) begin
			head_q   <= move_to;
			total_q  <= total_sat;
			idx_q    <= split_q;
			sweep2_q <= 1'b1;
		end
	end

	assign st.full         = (count_q == CW'(MAX_REQUESTS));
	assign st.count_zero   = (count_q == '0);
	assign st.idx_zero     = (idx_q == '0);
	assign st.idx_at_count = (idx_q == count_q);
	assign st.rd_gt_ld     = (rd_data_q > ld_q);
	assign st.rd_gt_head   = (rd_ext > head_q);
	assign st.dir_dn       = ~dir_up;
	assign st.sweep_done   = dir_up ? (idx_q == count_q) : (idx_q == '0);
	assign st.sweep2       = sweep2_q;
	assign st.all_done     = (em_q == count_q);
	assign st.em_last      = (em_q + 1'b1 == count_q);

	assign served_cylinder  = out_cyl_q;
	assign running_movement = total_q;
	assign is_empty         = empty_q;

endmodule

// File: sv/sdhs_ctrl.sv
module sdhs_ctrl import sdhs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    kind,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_LD_RD, S_LD_CMP, S_SC_RD, S_SC_CMP, S_SW_START,
		S_EM_RD, S_EM_CALC, S_END_TRAV, S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_RUN) begin
						cmd.run_start = 1'b1;
						state_d = st.count_zero ? S_OUT : S_SC_RD;
					end else if (!st.full) begin
						cmd.ld_start = 1'b1;
						state_d = S_LD_RD;
					end
				end
			end
			S_LD_RD: begin
				if (st.idx_zero) begin
					cmd.ld_place = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_dn = 1'b1;
					state_d = S_LD_CMP;
				end
			end
			S_LD_CMP: begin
				if (st.rd_gt_ld) begin
					cmd.ld_shift = 1'b1;
					state_d = S_LD_RD;
				end else begin
					cmd.ld_place = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SC_RD: begin
				if (st.idx_at_count) begin
					state_d = S_SW_START;
				end else begin
					cmd.rd_en = 1'b1;
					state_d = S_SC_CMP;
				end
			end
			S_SC_CMP: begin
				if (st.rd_gt_head) begin
					state_d = S_SW_START;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_SC_RD;
				end
			end
			S_SW_START: begin
				cmd.set_split = 1'b1;
				state_d = st.sweep_done ? S_END_TRAV : S_EM_RD;
			end
			S_EM_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_dn = st.dir_dn;
				state_d = S_EM_CALC;
			end
			S_EM_CALC: begin
				cmd.em_calc = 1'b1;
				state_d = (st.em_last && !st.sweep2) ? S_END_TRAV : S_OUT;
			end
			S_END_TRAV: begin
				cmd.end_trav = 1'b1;
				state_d = st.all_done ? S_OUT : S_EM_RD;
			end
			S_OUT: begin
				if (out_ready) begin
					if (st.all_done) begin
						cmd.clear_count = 1'b1;
						state_d = S_IDLE;
					end else if (st.sweep_done && !st.sweep2) begin
						state_d = S_END_TRAV;
					end else begin
						state_d = S_EM_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (state_d == S_OUT);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
